/* rtl/shared_pool_multi_stack_top_macros.svh */
// ----------------------------------------------------------------------------
// Shared pool multi-stack assertion macros
// Assertion macros used by the port checker of the shared pool multi-stack.
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_MULTI_STACK_TOP_MACROS_SVH
`define SHARED_POOL_MULTI_STACK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shared pool stack port check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shared pool stack port check failed");

`endif

/* rtl/spms_pkg.sv */
// ----------------------------------------------------------------------------
// Shared pool multi-stack package
// Beat types, operation and status codes, and controller handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package spms_pkg;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [1:0]         stack_id;
      logic signed [31:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic               now_empty;
   } rsp_item_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic finish_look;
      logic finish_fetch;
   } cmd_type;

   typedef struct packed {
      logic need_fetch;
      logic slot_free;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/shared_pool_multi_stack_top.sv */
// ----------------------------------------------------------------------------
// Shared pool multi-stack top level
// Several stacks share one pool of entries linked from each top downward.
//
//   channel   ports                          direction
//   request   req_valid req_stall req_data   in  (push, pop or peek)
//   response  rsp_valid rsp_stall rsp_data   out (one beat per request)
//
// A push ends in the lookup step that loads its response beat; a pop or peek
// adds a fetch step, the registered pool read, when its stack holds an entry.
// One request is in work at a time; the next is accepted the cycle after
// the response beat is loaded, even while that beat still waits.
// Free entries come from a fill count and a free list, so reset needs
// no clearing pass and the block is ready in the first cycle after reset.
// A stalled response beat holds the block in its final step until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_pool_multi_stack_top #(
   parameter int POOL_DEPTH  = 16,
   parameter int NUM_STACKS  = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire spms_pkg::req_item_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output spms_pkg::rsp_item_type      rsp_data
);

   spms_pkg::cmd_type cmd;
   spms_pkg::sts_type sts;

   spms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spms_datapath #(
      .POOL_DEPTH  (POOL_DEPTH),
      .NUM_STACKS  (NUM_STACKS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/spms_ctrl.sv */
// ----------------------------------------------------------------------------
// Shared pool multi-stack controller
// Sequences one operation at a time through lookup and entry fetch steps.
// ----------------------------------------------------------------------------
`default_nettype none

module spms_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire spms_pkg::sts_type sts,
   output spms_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            if (sts.need_fetch) begin
               cmd.fetch = 1'b1;
               state_in  = S_FETCH;
            end else if (sts.slot_free) begin
               cmd.finish_look = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FETCH: begin
            if (sts.slot_free) begin
               cmd.finish_fetch = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* rtl/spms_datapath.sv */
// ----------------------------------------------------------------------------
// Shared pool multi-stack datapath
// Entry pool, free list, stack tops and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spms_datapath #(
   parameter int POOL_DEPTH  = 16,
   parameter int NUM_STACKS  = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spms_pkg::req_item_type req_data,
   input  wire logic                   rsp_stall,
   input  wire spms_pkg::cmd_type      cmd,
   output spms_pkg::sts_type           sts,
   output logic                        rsp_valid,
   output spms_pkg::rsp_item_type      rsp_data
);

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int STK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];
   logic [IDX_W:0]         link_mem  [POOL_DEPTH];
   logic [IDX_W-1:0]       free_mem  [POOL_DEPTH];
   logic [IDX_W-1:0]       top_mem   [NUM_STACKS];

   spms_pkg::req_item_type req_ff;
   logic [IDX_W-1:0]       top_rd_ff;
   logic [IDX_W-1:0]       free_rd_ff;
   logic [VALUE_WIDTH-1:0] value_rd_ff;
   logic [IDX_W:0]         link_rd_ff;

   logic [NUM_STACKS-1:0]  top_valid_ff;
   logic [NUM_STACKS-1:0]  top_valid_in;
   logic [CNT_W-1:0]       fresh_ff;
   logic [CNT_W-1:0]       fresh_in;
   logic [CNT_W-1:0]       free_cnt_ff;
   logic [CNT_W-1:0]       free_cnt_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   spms_pkg::rsp_item_type rsp_data_ff;
   spms_pkg::rsp_item_type rsp_data_in;

   logic [31:0]            acc_wide;
   logic [STK_W-1:0]       acc_idx;
   logic [CNT_W-1:0]       free_last;
   logic [31:0]            sid_wide;
   logic [STK_W-1:0]       sid_idx;
   logic                   sid_ok;
   logic                   tv;
   logic                   is_push;
   logic                   is_pop;
   logic                   is_peek;
   logic                   have_free;
   logic                   have_fresh;
   logic                   full;
   logic                   push_ok;
   logic [IDX_W-1:0]       alloc_idx;
   logic signed [63:0]     val_ext;

   logic                   entry_we;
   logic [VALUE_WIDTH-1:0] value_wd;
   logic [IDX_W:0]         link_wd;
   logic                   top_we;
   logic [IDX_W-1:0]       top_wd;
   logic                   free_we;

   always_comb begin
      acc_wide  = 32'(req_data.stack_id);
      acc_idx   = acc_wide[STK_W-1:0];
      free_last = free_cnt_ff - CNT_ONE;
      sid_wide  = 32'(req_ff.stack_id);
      sid_idx   = sid_wide[STK_W-1:0];
      sid_ok    = (sid_wide < 32'(NUM_STACKS));
      tv        = sid_ok && top_valid_ff[sid_idx];
      is_push   = (req_ff.req_type == spms_pkg::OP_PUSH);
      is_pop    = (req_ff.req_type == spms_pkg::OP_POP);
      is_peek   = (req_ff.req_type == spms_pkg::OP_PEEK);
      have_free  = (free_cnt_ff != '0);
      have_fresh = (fresh_ff != CNT_FULL);
      full       = !have_free && !have_fresh;
      push_ok    = sid_ok && is_push && !full;
      alloc_idx  = have_free ? free_rd_ff : fresh_ff[IDX_W-1:0];
      val_ext    = 64'(signed'(value_rd_ff));
   end

   assign sts.need_fetch = sid_ok && (is_pop || is_peek) && tv;
   assign sts.slot_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      entry_we     = cmd.finish_look && push_ok;
      value_wd     = VALUE_WIDTH'($unsigned(req_ff.push_value));
      link_wd      = {tv, top_rd_ff};
      top_we       = 1'b0;
      top_wd       = alloc_idx;
      free_we      = cmd.finish_fetch && is_pop;
      top_valid_in = top_valid_ff;
      fresh_in     = fresh_ff;
      free_cnt_in  = free_cnt_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.finish_look) begin
         rsp_data_in.read_value = '0;
         if (!sid_ok) begin
            rsp_data_in.status = spms_pkg::STATUS_EMPTY;
         end else begin
            case (req_ff.req_type) inside
               spms_pkg::OP_PUSH: begin
                  rsp_data_in.status = full ? spms_pkg::STATUS_FULL : spms_pkg::STATUS_OK;
               end
               spms_pkg::OP_POP, spms_pkg::OP_PEEK: begin
                  rsp_data_in.status = spms_pkg::STATUS_EMPTY;
               end
               default: begin
                  rsp_data_in.status = spms_pkg::STATUS_OK;
               end
            endcase
         end
         rsp_data_in.now_empty = !sid_ok ? 1'b1 : (push_ok ? 1'b0 : !tv);
         if (push_ok) begin
            top_we                = 1'b1;
            top_wd                = alloc_idx;
            top_valid_in[sid_idx] = 1'b1;
            if (have_free) begin
               free_cnt_in = free_cnt_ff - CNT_ONE;
            end else begin
               fresh_in = fresh_ff + CNT_ONE;
            end
         end
      end

      if (cmd.finish_fetch) begin
         rsp_data_in.read_value = val_ext[31:0];
         rsp_data_in.status     = spms_pkg::STATUS_OK;
         rsp_data_in.now_empty  = is_pop ? !link_rd_ff[IDX_W] : 1'b0;
         if (is_pop) begin
            top_we                = 1'b1;
            top_wd                = link_rd_ff[IDX_W-1:0];
            top_valid_in[sid_idx] = link_rd_ff[IDX_W];
            free_cnt_in           = free_cnt_ff + CNT_ONE;
         end
      end

      if (cmd.finish_look || cmd.finish_fetch) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff     <= req_data;
         top_rd_ff  <= top_mem[acc_idx];
         free_rd_ff <= free_mem[free_last[IDX_W-1:0]];
      end
      if (cmd.fetch) begin
         value_rd_ff <= value_mem[top_rd_ff];
         link_rd_ff  <= link_mem[top_rd_ff];
      end
      if (entry_we) begin
         value_mem[alloc_idx] <= value_wd;
         link_mem[alloc_idx]  <= link_wd;
      end
      if (top_we) begin
         top_mem[sid_idx] <= top_wd;
      end
      if (free_we) begin
         free_mem[free_cnt_ff[IDX_W-1:0]] <= top_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_valid_ff <= '0;
         fresh_ff     <= '0;
         free_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_valid_ff <= top_valid_in;
         fresh_ff     <= fresh_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/spms_checker.sv */
// ----------------------------------------------------------------------------
// Shared pool multi-stack port checker
// Watches the top level's ports and flags behavior the block never shows.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shared_pool_multi_stack_top_macros.svh"

module spms_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire spms_pkg::req_item_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire spms_pkg::rsp_item_type rsp_data
);

   logic req_beat;
   logic req_wait;
   logic rsp_wait;
   logic rsp_error;
   logic rsp_empty;

   assign req_beat  = req_valid && !req_stall;
   assign req_wait  = req_valid && req_stall;
   assign rsp_wait  = rsp_valid && rsp_stall;
   assign rsp_error = rsp_valid && (rsp_data.status != spms_pkg::STATUS_OK);
   assign rsp_empty = rsp_valid && (rsp_data.status == spms_pkg::STATUS_EMPTY);

   `SPMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))
   `SPMS_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_data))
   `SPMS_ASSERT_NOW(a_err_zero, clock, reset, rsp_error, rsp_data.read_value == 32'sd0)
   `SPMS_ASSERT_NOW(a_empty_flag, clock, reset, rsp_empty, rsp_data.now_empty)
   `SPMS_ASSERT_NEXT(a_busy_after, clock, reset, req_beat, req_stall)

endmodule

bind shared_pool_multi_stack_top spms_checker u_spms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* test/tb_shared_pool_multi_stack_top.sv */
// ----------------------------------------------------------------------------
// Shared pool multi-stack testbench
// Drives push, pop, peek and unused-code beats into the block with random
// idles and stalls on both channels. A short table of directed beats comes
// first, followed by random traffic in phases that alternately fill and drain
// the shared pool. Every response beat is checked against its typed table
// entry or else a queue-based model of the stacks and the pool occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_shared_pool_multi_stack_top;

   localparam int          POOL_DEPTH   = 16;
   localparam int          NUM_STACKS   = 4;
   localparam int          RANDOM_BEATS = 525;
   localparam int          IDLE_PCT     = 19;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   typedef struct packed {
      spms_pkg::req_item_type req;
      logic                   typed;
      spms_pkg::rsp_item_type rsp;
   } directed_row_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   spms_pkg::req_item_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   spms_pkg::rsp_item_type rsp_data;

   bit                     calm = 1'b0;
   int                     fault_count = 0;
   int                     entries_in_use = 0;
   logic [31:0]            stack_values [NUM_STACKS][$];
   spms_pkg::rsp_item_type expected_rsps [$];

   directed_row_type directed_rows [0:24] = '{
      '{'{spms_pkg::OP_POP,  2'd0, 32'h0}, 1'b1, '{32'h0, spms_pkg::STATUS_EMPTY, 1'b1}},
      '{'{spms_pkg::OP_PEEK, 2'd3, 32'hFFFF_FFFF}, 1'b1,
        '{32'h0, spms_pkg::STATUS_EMPTY, 1'b1}},
      '{'{OP_UNUSED, 2'd2, 32'h1234_5678}, 1'b1, '{32'h0, spms_pkg::STATUS_OK, 1'b1}},
      '{'{spms_pkg::OP_PUSH, 2'd0, 32'h7FFF_FFFF}, 1'b1,
        '{32'h0, spms_pkg::STATUS_OK, 1'b0}},
      '{'{spms_pkg::OP_PUSH, 2'd1, 32'h8000_0000}, 1'b1,
        '{32'h0, spms_pkg::STATUS_OK, 1'b0}},
      '{'{spms_pkg::OP_PEEK, 2'd0, 32'h0}, 1'b1,
        '{32'h7FFF_FFFF, spms_pkg::STATUS_OK, 1'b0}},
      '{'{spms_pkg::OP_POP,  2'd1, 32'h0}, 1'b1,
        '{32'h8000_0000, spms_pkg::STATUS_OK, 1'b1}},
      '{'{OP_UNUSED, 2'd0, 32'h0}, 1'b1, '{32'h0, spms_pkg::STATUS_OK, 1'b0}},
      '{'{spms_pkg::OP_PUSH, 2'd0, 32'h0000_0000}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd1, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd2, 32'hA5A5_A5A5}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd3, 32'h5A5A_5A5A}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd0, 32'h0000_0001}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd1, 32'h8000_0001}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd2, 32'h7FFF_FFFE}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd3, 32'h0F0F_0F0F}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd0, 32'hF0F0_F0F0}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd1, 32'h3333_3333}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd2, 32'hCCCC_CCCC}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd3, 32'h0000_FFFF}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd0, 32'hFFFF_0000}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd1, 32'h1357_9BDF}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd2, 32'hECA8_6420}, 1'b0, '0},
      '{'{spms_pkg::OP_PUSH, 2'd3, 32'h0000_0001}, 1'b1,
        '{32'h0, spms_pkg::STATUS_FULL, 1'b0}},
      '{'{spms_pkg::OP_POP,  2'd2, 32'h0000_0000}, 1'b0, '0}
   };

   shared_pool_multi_stack_top #(
      .POOL_DEPTH  (POOL_DEPTH),
      .NUM_STACKS  (NUM_STACKS),
      .VALUE_WIDTH (32)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_shared_pool_multi_stack_top: done, errors");
      $finish;
   end

   function automatic spms_pkg::rsp_item_type apply_stack_op(
      input spms_pkg::req_item_type op_req);
      spms_pkg::rsp_item_type result;
      int unsigned            sid;
      result = '0;
      sid = 32'(op_req.stack_id);
      case (op_req.req_type) inside
         spms_pkg::OP_PUSH: begin
            if (entries_in_use == POOL_DEPTH) begin
               result.status = spms_pkg::STATUS_FULL;
            end else begin
               stack_values[sid].push_back(op_req.push_value);
               entries_in_use++;
            end
         end
         spms_pkg::OP_POP, spms_pkg::OP_PEEK: begin
            if (stack_values[sid].size() == 0) begin
               result.status = spms_pkg::STATUS_EMPTY;
            end else begin
               result.read_value = stack_values[sid][$];
               if (op_req.req_type == spms_pkg::OP_POP) begin
                  void'(stack_values[sid].pop_back());
                  entries_in_use--;
               end
            end
         end
         default: begin
         end
      endcase
      result.now_empty = (stack_values[sid].size() == 0);
      return result;
   endfunction

   task automatic send_beat(input spms_pkg::req_item_type item, input logic typed,
                            input spms_pkg::rsp_item_type typed_rsp);
      spms_pkg::rsp_item_type predicted;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_stack_op(item);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   always @(posedge clock) begin
      spms_pkg::rsp_item_type want;
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, rsp_data);
            fault_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.read_value !== want.read_value || rsp_data.status !== want.status ||
                rsp_data.now_empty !== want.now_empty) begin
               $display("%0t: expected value %h status %0d empty %0d, got %h %0d %0d",
                        $time, want.read_value, want.status, want.now_empty,
                        rsp_data.read_value, rsp_data.status, rsp_data.now_empty);
               fault_count++;
            end
         end
      end
   end

   initial begin
      spms_pkg::req_item_type beat;
      int unsigned            push_share;
      int unsigned            pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // Push-heavy and pop-heavy phases alternate so the pool both fills and drains.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n >= 250 && n < 330);
         push_share = ((n / 60) % 2 == 0) ? 75 : 25;
         beat = '0;
         beat.stack_id = 2'($urandom_range(NUM_STACKS - 1));
         pick = $urandom_range(99);
         if ($urandom_range(99) < 3) begin
            beat.req_type = OP_UNUSED;
         end else if (pick < push_share) begin
            beat.req_type = spms_pkg::OP_PUSH;
         end else if (pick < push_share + (100 - push_share) * 2 / 3) begin
            beat.req_type = spms_pkg::OP_POP;
         end else begin
            beat.req_type = spms_pkg::OP_PEEK;
         end
         case ($urandom_range(9))
            0:       beat.push_value = 32'h7FFF_FFFF;
            1:       beat.push_value = 32'h8000_0000;
            2:       beat.push_value = 32'h0000_0000;
            default: beat.push_value = $urandom;
         endcase
         send_beat(beat, 1'b0, '0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_shared_pool_multi_stack_top: done, clean");
      end else begin
         $display("tb_shared_pool_multi_stack_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
